>>> hdl/lsmb_pkg.sv
// Package for the log-softmax backward row unit: widths, FSM state type,
// and the exp(-t) interpolation table built at elaboration.
// No dependencies.
package lsmb_pkg;

    // Row storage
    localparam int MAX_ROW = 64;
    localparam int ADDR_W  = $clog2(MAX_ROW);
    localparam int CNT_W   = $clog2(MAX_ROW + 1);

    // Data path widths
    localparam int DATA_W   = 32;
    localparam int SUM_W    = 39;
    localparam int MAG_LO_W = 20;
    localparam int MAG_HI_W = SUM_W - MAG_LO_W;
    localparam int EXP_W    = 17;
    localparam int PROD_W   = SUM_W + EXP_W;
    localparam int RES_W    = PROD_W - 16 + 2;

    // Exp table geometry: 2^EXP_TABLE_BITS segments over t in [0,16]
    localparam int EXP_TABLE_BITS = 8;
    localparam int SEGS           = 1 << EXP_TABLE_BITS;
    localparam int SEG_SHIFT      = 20 - EXP_TABLE_BITS;
    localparam int IDX_W          = EXP_TABLE_BITS + 1;
    localparam int D_W            = 21;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    typedef logic [EXP_W-1:0] exp_tbl_t [0:SEGS];

    // Series term divided by its index (constant divisors only)
    function automatic logic [63:0] div_by_index(input logic [63:0] term, input int k);
        logic [63:0] q;
        case (k)
            1:       q = term;
            2:       q = term / 64'd2;
            3:       q = term / 64'd3;
            4:       q = term / 64'd4;
            5:       q = term / 64'd5;
            6:       q = term / 64'd6;
            7:       q = term / 64'd7;
            8:       q = term / 64'd8;
            9:       q = term / 64'd9;
            10:      q = term / 64'd10;
            11:      q = term / 64'd11;
            12:      q = term / 64'd12;
            13:      q = term / 64'd13;
            14:      q = term / 64'd14;
            15:      q = term / 64'd15;
            16:      q = term / 64'd16;
            17:      q = term / 64'd17;
            18:      q = term / 64'd18;
            19:      q = term / 64'd19;
            20:      q = term / 64'd20;
            default: q = term;
        endcase
        return q;
    endfunction

    // exp(-f) for f in Q30 within [0,1], result Q30, 20-term series
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
        logic [63:0]        term;
        logic signed [63:0] acc;
        term = Q30_ONE;
        acc  = $signed(Q30_ONE);
        for (int k = 1; k <= 20; k++) begin
            term = (term * f) >> 30;
            term = div_by_index(term, k);
            if ((k % 2) == 1)
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
        end
        if (acc < 0)
            acc = '0;
        return $unsigned(acc);
    endfunction

    // Table entry k = exp(-k*16/SEGS) in Q16.16
    function automatic exp_tbl_t build_exp_tbl();
        exp_tbl_t    tbl;
        logic [63:0] e1;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] v;
        e1 = exp_neg_q30(Q30_ONE);
        for (int k = 0; k <= SEGS; k++) begin
            t = 64'(k) << SEG_SHIFT;
            n = t >> 16;
            v = exp_neg_q30((t & 64'hFFFF) << 14);
            for (int i = 0; i < int'(n); i++)
                v = (v * e1 + (64'd1 << 29)) >> 30;
            tbl[k] = EXP_W'((v + (64'd1 << 13)) >> 14);
        end
        return tbl;
    endfunction

    localparam exp_tbl_t EXP_TBL = build_exp_tbl();

endpackage

>>> hdl/log_softmax_backward_row_unit.sv
// Log-softmax backward over one row: stores the row in a synchronous RAM,
// sums the gradients, then streams grad_i - exp(logprob_i)*sum.
// Depends on lsmb_pkg.
//
// Load phase: one element per cycle, written to the row RAM at the fill count.
// Emit phase: one RAM read per cycle feeding a 7-stage pipeline, then one result
// per cycle; reads and results both stall while a result waits on m_tready.
// No input is taken while emitting.
// Reset clears the FSM, fill count, sum and overflow flag; the RAM is not cleared.
module log_softmax_backward_row_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [2*lsmb_pkg::DATA_W-1:0] s_tdata,   // [31:0] grad_value, [63:32] log_prob
    input  logic                          s_tlast,   // last_in_row
    // master side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lsmb_pkg::DATA_W-1:0]   m_tdata,   // [31:0] grad_result
    output logic                          m_tlast,   // last_out
    output logic                          m_tuser    // [0] row_overflowed
);
    import lsmb_pkg::*;

    // Control state
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic                      ovf_reg, ovf_next;
    logic [CNT_W-1:0]          issue_reg, issue_next;

    // Row RAM
    logic [2*DATA_W-1:0]       row_mem [0:MAX_ROW-1];
    logic [2*DATA_W-1:0]       rd_data_reg;

    // Pipeline valid and last tags
    logic                      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic                      l1_reg, l2_reg, l3_reg, l4_reg, l5_reg, l6_reg;

    // Pipeline payload
    logic [SUM_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic [D_W-1:0]            d_reg;
    logic signed [DATA_W-1:0]  g2_reg, g3_reg, g4_reg, g5_reg, g6_reg;
    logic [EXP_W-1:0]          t0_reg, dt_reg;
    logic [SEG_SHIFT-1:0]      rem_reg;
    logic [EXP_W-1:0]          e4_reg, e5_reg;
    logic [MAG_LO_W+EXP_W-1:0] plo_reg;
    logic [PROD_W-1:0]         prod_reg;

    // Output register
    logic                      out_valid_reg;
    logic [DATA_W-1:0]         out_data_reg;
    logic                      out_last_reg;
    logic                      out_ovf_reg;

    logic                      in_xact, out_xact, adv, issue, store_ok;

    // Handshake
    assign in_xact  = s_tvalid && s_tready;
    assign out_xact = out_valid_reg && m_tready;
    assign adv      = !out_valid_reg || m_tready;
    assign store_ok = cnt_reg < CNT_W'(MAX_ROW);
    assign issue    = (state_reg == ST_EMIT) && adv && (issue_reg < cnt_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_xact && s_tlast)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_xact && out_last_reg)
                    state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        case (state_reg)
            ST_LOAD: s_tready = 1'b1;
            ST_EMIT: s_tready = 1'b0;
            default: s_tready = 1'b0;
        endcase
    end

    // Row bookkeeping: fill count, gradient sum, overflow flag, read pointer
    always_comb
    begin
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        issue_next = issue_reg;
        if (state_reg == ST_LOAD) begin
            issue_next = '0;
            if (in_xact) begin
                if (store_ok) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    sum_next = sum_reg + SUM_W'($signed(s_tdata[DATA_W-1:0]));
                end else begin
                    ovf_next = 1'b1;
                end
            end
        end else begin
            if (issue)
                issue_next = issue_reg + CNT_W'(1);
            if (out_xact && out_last_reg) begin
                cnt_next = '0;
                sum_next = '0;
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            issue_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            issue_reg <= issue_next;
        end
    end

    // Row RAM write port
    always_ff @(posedge clk)
    begin
        if (in_xact && store_ok)
            row_mem[cnt_reg[ADDR_W-1:0]] <= s_tdata;
    end

    // Row RAM read port, held while the pipeline stalls
    always_ff @(posedge clk)
    begin
        if (issue)
            rd_data_reg <= row_mem[issue_reg[ADDR_W-1:0]];
    end

    // Sum magnitude and sign, stable through the emit phase
    always_ff @(posedge clk)
    begin
        neg_reg <= sum_reg < 0;
        mag_reg <= (sum_reg < 0) ? $unsigned(-sum_reg) : $unsigned(sum_reg);
    end

    // Valid and last tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            out_valid_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            l1_reg <= issue_reg == (cnt_reg - CNT_W'(1));
            l2_reg <= l1_reg;
            l3_reg <= l2_reg;
            l4_reg <= l3_reg;
            l5_reg <= l4_reg;
            l6_reg <= l5_reg;
        end
    end

    // Stage 2: clamp log_prob to [-16,0] and negate
    logic signed [DATA_W-1:0] lp;
    logic [DATA_W-1:0]        lp_neg;
    logic [D_W-1:0]           d_calc;

    always_comb
    begin
        lp     = $signed(rd_data_reg[2*DATA_W-1:DATA_W]);
        lp_neg = $unsigned(-lp);
        if (lp > 0)
            d_calc = '0;
        else if (lp < -(DATA_W'(1) << 20))
            d_calc = D_W'(1) << 20;
        else
            d_calc = lp_neg[D_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            d_reg  <= d_calc;
            g2_reg <= $signed(rd_data_reg[DATA_W-1:0]);
        end
    end

    // Stage 3: table lookup of both segment ends
    logic [IDX_W-1:0] idx0, idx1;

    always_comb
    begin
        idx0 = d_reg[D_W-1:SEG_SHIFT];
        idx1 = (idx0 == IDX_W'(SEGS)) ? idx0 : idx0 + IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            t0_reg  <= EXP_TBL[idx0];
            dt_reg  <= EXP_TBL[idx0] - EXP_TBL[idx1];
            rem_reg <= d_reg[SEG_SHIFT-1:0];
            g3_reg  <= g2_reg;
        end
    end

    // Stage 4: interpolate, t0 - (t0 - t1)*rem/step with rounding
    logic [EXP_W+SEG_SHIFT-1:0] slope_prod;
    logic [EXP_W+SEG_SHIFT:0]   interp;

    always_comb
    begin
        slope_prod = (EXP_W+SEG_SHIFT)'(dt_reg) * (EXP_W+SEG_SHIFT)'(rem_reg);
        interp     = ((EXP_W+SEG_SHIFT+1)'(t0_reg) << SEG_SHIFT)
                     - (EXP_W+SEG_SHIFT+1)'(slope_prod)
                     + ((EXP_W+SEG_SHIFT+1)'(1) << (SEG_SHIFT - 1));
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            e4_reg <= interp[EXP_W+SEG_SHIFT-1:SEG_SHIFT];
            g4_reg <= g3_reg;
        end
    end

    // Stage 5: low partial product of |sum| * exp
    always_ff @(posedge clk)
    begin
        if (adv) begin
            plo_reg <= (MAG_LO_W+EXP_W)'(mag_reg[MAG_LO_W-1:0])
                       * (MAG_LO_W+EXP_W)'(e4_reg);
            e5_reg  <= e4_reg;
            g5_reg  <= g4_reg;
        end
    end

    // Stage 6: high partial product and combine
    logic [MAG_HI_W+EXP_W-1:0] phi;

    assign phi = (MAG_HI_W+EXP_W)'(mag_reg[SUM_W-1:MAG_LO_W]) * (MAG_HI_W+EXP_W)'(e5_reg);

    always_ff @(posedge clk)
    begin
        if (adv) begin
            prod_reg <= (PROD_W'(phi) << MAG_LO_W) + PROD_W'(plo_reg);
            g6_reg   <= g5_reg;
        end
    end

    // Stage 7: round to Q16.16, subtract from gradient, saturate
    logic [PROD_W:0]          rnd;
    logic [PROD_W-16:0]       r;
    logic signed [RES_W-1:0]  res;
    logic [DATA_W-1:0]        sat;

    always_comb
    begin
        rnd = (PROD_W+1)'(prod_reg) + (PROD_W+1)'(32768);
        r   = rnd[PROD_W:16];
        if (neg_reg)
            res = RES_W'(g6_reg) + $signed(RES_W'(r));
        else
            res = RES_W'(g6_reg) - $signed(RES_W'(r));
        if (res > RES_W'(32'sh7FFF_FFFF))
            sat = 32'h7FFF_FFFF;
        else if (res < -RES_W'(33'sh0_8000_0000))
            sat = 32'h8000_0000;
        else
            sat = res[DATA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            out_data_reg <= sat;
            out_last_reg <= l6_reg;
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

endmodule
